>>> hdl/rcfs_pkg.sv
// Package for the RC failsafe ramp controller.
// Holds widths, reset values, register map, config struct and the shared
// mapping/slew functions. No dependencies.
package rcfs_pkg;

    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int IN_DW     = 24;
    localparam int OUT_DW    = 56;
    localparam int THR_W     = 12;
    localparam int SRV_W     = 8;
    localparam int CNT_W     = 16;
    localparam int LOST_W    = 32;
    localparam int PROD_W    = 22;

    localparam logic [THR_W-1:0] THR_MIN_RST  = 12'd1000;
    localparam logic [THR_W-1:0] THR_MAX_RST  = 12'd2000;
    localparam logic [THR_W-1:0] THR_SAFE_RST = 12'd1000;
    localparam logic [SRV_W-1:0] SRV_MIN_RST  = 8'd20;
    localparam logic [SRV_W-1:0] SRV_MAX_RST  = 8'd160;
    localparam logic [SRV_W-1:0] SRV_CTR_RST  = 8'd90;
    localparam logic [7:0]       RAMP_RST     = 8'd4;
    localparam logic [CNT_W-1:0] TIMEOUT_RST  = 16'd80;
    localparam logic [CNT_W-1:0] COOLDOWN_RST = 16'd150;
    localparam logic [CNT_W-1:0] CNT_SAT      = 16'hFFFF;
    localparam logic [7:0]       SRV_STEP     = 8'd2;

    // floor(m / 127) == (m * RECIP_K) >> RECIP_SH for m below 2^19
    localparam logic [19:0]      RECIP_K      = 20'd528417;
    localparam int               RECIP_SH     = 26;

    typedef enum logic [2:0] {
        REG_THR_MIN  = 3'd0,
        REG_THR_MAX  = 3'd1,
        REG_THR_SAFE = 3'd2,
        REG_SRV_MIN  = 3'd3,
        REG_SRV_MAX  = 3'd4,
        REG_RAMP     = 3'd5,
        REG_TIMEOUT  = 3'd6,
        REG_COOLDOWN = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [THR_W-1:0] thr_min;
        logic [THR_W-1:0] thr_max;
        logic [THR_W-1:0] thr_safe;
        logic [SRV_W-1:0] srv_min;
        logic [SRV_W-1:0] srv_max;
        logic [7:0]       ramp;
        logic [CNT_W-1:0] timeout;
        logic [CNT_W-1:0] cooldown;
    } cfg_t;

    // (b - 1) * (hi - lo), first half of the linear map
    function automatic logic signed [PROD_W-1:0] scale_prod(
        input logic [7:0]       b,
        input logic [THR_W-1:0] lo,
        input logic [THR_W-1:0] hi
    );
        logic signed [8:0]  b1;
        logic signed [12:0] span;
        b1   = $signed({1'b0, b}) - 9'sd1;
        span = $signed({1'b0, hi}) - $signed({1'b0, lo});
        return b1 * span;
    endfunction

    // prod / 254 truncated toward zero, plus lo, clamped to lo then hi
    function automatic logic [THR_W-1:0] scale_finish(
        input logic signed [PROD_W-1:0] prod,
        input logic [THR_W-1:0]         lo,
        input logic [THR_W-1:0]         hi
    );
        logic [PROD_W-2:0]  mag;
        logic [18:0]        half;
        logic [38:0]        qk;
        logic [12:0]        q;
        logic signed [13:0] v;
        logic signed [14:0] sum;
        logic [THR_W-1:0]   res;
        mag  = prod[PROD_W-1] ? (PROD_W-1)'(-prod) : prod[PROD_W-2:0];
        half = mag[19:1];
        qk   = half * RECIP_K;
        q    = {1'b0, qk[RECIP_SH+11:RECIP_SH]};
        v    = prod[PROD_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        sum  = 15'(v) + $signed({3'b0, lo});
        if (sum < $signed({3'b0, lo})) begin
            res = lo;
        end else if (sum > $signed({3'b0, hi})) begin
            res = hi;
        end else begin
            res = sum[THR_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [THR_W-1:0] slew(
        input logic [THR_W-1:0] cur,
        input logic [THR_W-1:0] tgt,
        input logic [7:0]       step
    );
        logic [THR_W-1:0] res;
        if (cur < tgt) begin
            res = ((tgt - cur) > {4'b0, step}) ? cur + {4'b0, step} : tgt;
        end else if (cur > tgt) begin
            res = ((cur - tgt) > {4'b0, step}) ? cur - {4'b0, step} : tgt;
        end else begin
            res = cur;
        end
        return res;
    endfunction

endpackage

>>> hdl/rcfs_cfg.sv
// APB register file of the RC failsafe ramp controller.
// Depends on rcfs_pkg for the register map and cfg_t.
module rcfs_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rcfs_pkg::APB_AW-1:0] paddr,
    input  logic [rcfs_pkg::APB_DW-1:0] pwdata,
    output logic [rcfs_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output rcfs_pkg::cfg_t              cfg
);
    import rcfs_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.thr_min  <= THR_MIN_RST;
            cfg_reg.thr_max  <= THR_MAX_RST;
            cfg_reg.thr_safe <= THR_SAFE_RST;
            cfg_reg.srv_min  <= SRV_MIN_RST;
            cfg_reg.srv_max  <= SRV_MAX_RST;
            cfg_reg.ramp     <= RAMP_RST;
            cfg_reg.timeout  <= TIMEOUT_RST;
            cfg_reg.cooldown <= COOLDOWN_RST;
        end else if (wr_en) begin
            case (idx)
                REG_THR_MIN:  cfg_reg.thr_min  <= pwdata[THR_W-1:0];
                REG_THR_MAX:  cfg_reg.thr_max  <= pwdata[THR_W-1:0];
                REG_THR_SAFE: cfg_reg.thr_safe <= pwdata[THR_W-1:0];
                REG_SRV_MIN:  cfg_reg.srv_min  <= pwdata[SRV_W-1:0];
                REG_SRV_MAX:  cfg_reg.srv_max  <= pwdata[SRV_W-1:0];
                REG_RAMP:     cfg_reg.ramp     <= pwdata[7:0];
                REG_TIMEOUT:  cfg_reg.timeout  <= pwdata[CNT_W-1:0];
                REG_COOLDOWN: cfg_reg.cooldown <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_THR_MIN:  prdata = APB_DW'(cfg_reg.thr_min);
            REG_THR_MAX:  prdata = APB_DW'(cfg_reg.thr_max);
            REG_THR_SAFE: prdata = APB_DW'(cfg_reg.thr_safe);
            REG_SRV_MIN:  prdata = APB_DW'(cfg_reg.srv_min);
            REG_SRV_MAX:  prdata = APB_DW'(cfg_reg.srv_max);
            REG_RAMP:     prdata = APB_DW'(cfg_reg.ramp);
            REG_TIMEOUT:  prdata = APB_DW'(cfg_reg.timeout);
            REG_COOLDOWN: prdata = APB_DW'(cfg_reg.cooldown);
            default:      prdata = '0;
        endcase
    end

endmodule

>>> hdl/rcfs_outq.sv
// Two-word result queue of the RC failsafe ramp controller: output
// register plus skid word. Depends on rcfs_pkg for the word width.
module rcfs_outq (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  logic [rcfs_pkg::OUT_DW-1:0] push_data,
    output logic                        ready,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [rcfs_pkg::OUT_DW-1:0] m_tdata
);
    import rcfs_pkg::*;

    logic [1:0]        count_reg, count_next;
    logic [OUT_DW-1:0] head_reg, head_next;
    logic [OUT_DW-1:0] tail_reg, tail_next;
    logic              pop;

    assign m_tvalid = (count_reg != 2'd0);
    assign ready    = (count_reg != 2'd2);
    assign m_tdata  = head_reg;
    assign pop      = m_tvalid && m_tready;

    always_comb begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        if (pop && push) begin
            if (count_reg == 2'd1) begin
                head_next = push_data;
            end else begin
                head_next = tail_reg;
                tail_next = push_data;
            end
        end else if (pop) begin
            head_next  = tail_reg;
            count_next = count_reg - 2'd1;
        end else if (push) begin
            if (count_reg == 2'd0) begin
                head_next = push_data;
            end else begin
                tail_next = push_data;
            end
            count_next = count_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

>>> hdl/rc_failsafe_ramp_controller.sv
// RC receiver failsafe with slew-limited throttle and servo outputs.
// Depends on rcfs_pkg, rcfs_cfg and rcfs_outq.
//
//   port group | dir | word contents
//   s_         | in  | tdata: stick_x, stick_y, sequence_req; tuser: action
//   m_         | out | tdata: throttle, servo, link_up, lost, reinit
//   apb        | in  | eight config registers at byte offsets 0..28
//
// One word per cycle; the result is queued at the edge that takes the word.
// A packet's stick mapping finishes in the cycle after it (product, then reciprocal
// divide); a tick in that cycle uses the just-finished target directly.
// s_tready drops only while both result slots are full.
// Reset is synchronous, active low, and loads the register reset values.
module rc_failsafe_ramp_controller (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [rcfs_pkg::IN_DW-1:0]   s_tdata,  // stick_x, stick_y, sequence_req
    input  logic                         s_tuser,  // action
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [rcfs_pkg::OUT_DW-1:0]  m_tdata,  // throttle, servo, link_up, lost, reinit, pad
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rcfs_pkg::APB_AW-1:0]  paddr,
    input  logic [rcfs_pkg::APB_DW-1:0]  pwdata,
    output logic [rcfs_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import rcfs_pkg::*;

    cfg_t cfg;

    logic [7:0] stick_x, stick_y, seq_in;
    logic       accept, is_pkt, is_tick;

    logic [THR_W-1:0]         thr_tgt_reg, thr_tgt_next;
    logic [THR_W-1:0]         thr_cur_reg, thr_cur_next;
    logic [SRV_W-1:0]         srv_tgt_reg, srv_tgt_next;
    logic [SRV_W-1:0]         srv_cur_reg, srv_cur_next;
    logic [7:0]               prev_seq_reg, prev_seq_next;
    logic                     seen_reg, seen_next;
    logic [LOST_W-1:0]        lost_reg, lost_next;
    logic                     link_reg, link_next;
    logic [CNT_W-1:0]         sil_reg, sil_next;
    logic [CNT_W-1:0]         tsr_reg, tsr_next;

    // pending packet mapping
    logic                     pend_reg;
    logic signed [PROD_W-1:0] pthr_prod_reg, psrv_prod_reg;
    logic [THR_W-1:0]         pthr_lo_reg, pthr_hi_reg;
    logic [SRV_W-1:0]         psrv_lo_reg, psrv_hi_reg;

    logic [THR_W-1:0]  thr_map, thr_eff;
    logic [THR_W-1:0]  srv_map;
    logic [SRV_W-1:0]  srv_eff, srv_ctr;
    logic [8:0]        srv_sum;
    logic [7:0]        seq_gap;
    logic [LOST_W:0]   lost_sum;
    logic [CNT_W-1:0]  sil_inc, tsr_inc;
    logic              timed_out, reinit;
    logic [THR_W-1:0]  srv_slew;
    logic [OUT_DW-1:0] res_word;

    rcfs_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign stick_x = s_tdata[7:0];
    assign stick_y = s_tdata[15:8];
    assign seq_in  = s_tdata[23:16];
    assign accept  = s_tvalid && s_tready;
    assign is_pkt  = accept && !s_tuser;
    assign is_tick = accept && s_tuser;

    assign srv_sum = {1'b0, cfg.srv_min} + {1'b0, cfg.srv_max};
    assign srv_ctr = srv_sum[8:1];

    assign thr_map = scale_finish(pthr_prod_reg, pthr_lo_reg, pthr_hi_reg);
    assign srv_map = scale_finish(psrv_prod_reg, {4'b0, psrv_lo_reg}, {4'b0, psrv_hi_reg});
    assign thr_eff = pend_reg ? thr_map : thr_tgt_reg;
    assign srv_eff = pend_reg ? srv_map[SRV_W-1:0] : srv_tgt_reg;

    assign seq_gap  = seq_in - prev_seq_reg - 8'd1;
    assign lost_sum = {1'b0, lost_reg} + {25'b0, seq_gap};

    assign sil_inc   = (sil_reg == CNT_SAT) ? sil_reg : sil_reg + 16'd1;
    assign tsr_inc   = (tsr_reg == CNT_SAT) ? tsr_reg : tsr_reg + 16'd1;
    assign timed_out = sil_inc > cfg.timeout;
    assign reinit    = is_tick && timed_out && (tsr_inc > cfg.cooldown);

    always_comb begin
        thr_tgt_next  = thr_eff;
        srv_tgt_next  = srv_eff;
        thr_cur_next  = thr_cur_reg;
        srv_cur_next  = srv_cur_reg;
        prev_seq_next = prev_seq_reg;
        seen_next     = seen_reg;
        lost_next     = lost_reg;
        link_next     = link_reg;
        sil_next      = sil_reg;
        tsr_next      = tsr_reg;
        srv_slew      = '0;
        if (is_pkt) begin
            link_next     = 1'b1;
            sil_next      = '0;
            seen_next     = 1'b1;
            prev_seq_next = seq_in;
            if (seen_reg) begin
                lost_next = lost_sum[LOST_W] ? {LOST_W{1'b1}} : lost_sum[LOST_W-1:0];
            end
        end else if (is_tick) begin
            sil_next = sil_inc;
            tsr_next = reinit ? '0 : tsr_inc;
            if (timed_out) begin
                link_next    = 1'b0;
                thr_tgt_next = cfg.thr_safe;
                srv_tgt_next = srv_ctr;
            end
            thr_cur_next = slew(thr_cur_reg, thr_tgt_next, cfg.ramp);
            srv_slew     = slew({4'b0, srv_cur_reg}, {4'b0, srv_tgt_next}, SRV_STEP);
            srv_cur_next = srv_slew[SRV_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_tgt_reg  <= THR_SAFE_RST;
            thr_cur_reg  <= THR_SAFE_RST;
            srv_tgt_reg  <= SRV_CTR_RST;
            srv_cur_reg  <= SRV_CTR_RST;
            prev_seq_reg <= '0;
            seen_reg     <= 1'b0;
            lost_reg     <= '0;
            link_reg     <= 1'b0;
            sil_reg      <= '0;
            tsr_reg      <= CNT_SAT;
            pend_reg     <= 1'b0;
        end else begin
            thr_tgt_reg  <= thr_tgt_next;
            thr_cur_reg  <= thr_cur_next;
            srv_tgt_reg  <= srv_tgt_next;
            srv_cur_reg  <= srv_cur_next;
            prev_seq_reg <= prev_seq_next;
            seen_reg     <= seen_next;
            lost_reg     <= lost_next;
            link_reg     <= link_next;
            sil_reg      <= sil_next;
            tsr_reg      <= tsr_next;
            pend_reg     <= is_pkt;
        end
        if (is_pkt) begin
            pthr_prod_reg <= scale_prod(stick_x, cfg.thr_min, cfg.thr_max);
            psrv_prod_reg <= scale_prod(stick_y, {4'b0, cfg.srv_min}, {4'b0, cfg.srv_max});
            pthr_lo_reg   <= cfg.thr_min;
            pthr_hi_reg   <= cfg.thr_max;
            psrv_lo_reg   <= cfg.srv_min;
            psrv_hi_reg   <= cfg.srv_max;
        end
    end

    assign res_word = {2'b0, reinit, lost_next, link_next, srv_cur_next, thr_cur_next};

    rcfs_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (res_word),
        .ready     (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

>>> hdl/rcfs_checker.sv
// Port-level checker for the RC failsafe ramp controller, with its bind.
// Depends on rcfs_pkg for port widths.
module rcfs_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [rcfs_pkg::OUT_DW-1:0] m_tdata
);
    import rcfs_pkg::*;

    // a reinit request only comes with the link down
    a_reinit_link: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[53] |-> !m_tdata[20])
        else $error("reinit word with link up");

    // a taken word always leaves a result pending
    a_accept_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted word produced no result");

    // out of reset: queue empty, input open
    a_reset_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> s_tready && !m_tvalid)
        else $error("bad state after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed under stall");

endmodule

bind rc_failsafe_ramp_controller rcfs_checker u_rcfs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
